>>> rtl/core/prd_pkg.sv
// Shared types and constants for the partition record decoder.
package prd_pkg;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_PID,
        PH_TID_HI,
        PH_TID_LO,
        PH_RCOUNT,
        PH_REPL,
        PH_ICOUNT,
        PH_ISR,
        PH_SKIP,
        PH_LEADER,
        PH_LEPOCH,
        PH_PEPOCH,
        PH_DRAIN
    } phase_t;

    localparam logic [2:0] KIND_PID     = 3'd0;
    localparam logic [2:0] KIND_TID_HI  = 3'd1;
    localparam logic [2:0] KIND_TID_LO  = 3'd2;
    localparam logic [2:0] KIND_REPLICA = 3'd3;
    localparam logic [2:0] KIND_INSYNC  = 3'd4;
    localparam logic [2:0] KIND_LEADER  = 3'd5;
    localparam logic [2:0] KIND_LEPOCH  = 3'd6;
    localparam logic [2:0] KIND_PEPOCH  = 3'd7;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TRUNCATED = 2'd1;
    localparam logic [1:0] ERR_BAD_COUNT = 2'd2;

    localparam logic [4:0] LEN_WORD  = 5'd4;
    localparam logic [4:0] LEN_DWORD = 5'd8;
    localparam logic [4:0] LEN_SKIP  = 5'd2;

    typedef struct packed {
        phase_t      phase;
        logic [4:0]  byte_in_field;
        logic [63:0] value_shift;
        logic [7:0]  entries_left;
        logic [7:0]  entry_position;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  field_kind;
        logic [7:0]  entry_index;
        logic [63:0] field_value;
        logic        record_done;
        logic [1:0]  error_code;
    } field_result_t;

    // Parser state at reset and after every record end.
    function automatic parse_state_t restart_state(input logic has_header);
        parse_state_t s;
        s                = '0;
        s.phase          = has_header ? PH_HEADER : PH_PID;
        return s;
    endfunction

endpackage

>>> rtl/core/partition_record_decoder.sv
// Partition metadata record decoder: byte stream in, decoded fields out.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------------------
//  bytes   | byte_valid  | byte_stall  | data_byte, end_of_record
//  fields  | field_valid | field_stall | field_kind, entry_index, field_value,
//          |             |             | record_done, error_code
//
// One byte per cycle while byte_stall is low. A byte is parsed in the cycle it
// is accepted and its field (if any) sits in the single result register on the
// next cycle.
// Reset enters the header phase (PID if HEADER_BYTES is 0), result register empty.
// A held result with field_stall high stalls the byte side; a result taken in
// the same cycle frees the register for the next byte, so no bubble is added.
module partition_record_decoder #(
    parameter int HEADER_BYTES = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_record,
    output logic        field_valid,
    input  logic        field_stall,
    output logic [2:0]  field_kind,
    output logic [7:0]  entry_index,
    output logic [63:0] field_value,
    output logic        record_done,
    output logic [1:0]  error_code
);

    prd_pkg::parse_state_t  state_reg;
    prd_pkg::parse_state_t  state_next;
    prd_pkg::parse_state_t  step_state;
    prd_pkg::field_result_t step_res;
    prd_pkg::field_result_t result_reg;
    logic                   step_emit;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   accept;

    // Result register is free when empty or being taken this cycle.
    assign byte_stall = valid_reg && field_stall;
    assign accept     = byte_valid && !byte_stall;

    prd_step #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_step (
        .cur           (state_reg),
        .data_byte     (data_byte),
        .end_of_record (end_of_record),
        .nxt           (step_state),
        .emit          (step_emit),
        .res           (step_res)
    );

    assign state_next = accept ? step_state : state_reg;

    always_comb
    begin
        if (accept && step_emit)
            valid_next = 1'b1;
        else if (valid_reg && field_stall)
            valid_next = 1'b1;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prd_pkg::restart_state(HEADER_BYTES > 0);
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Payload only loads on a new request; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept && step_emit)
            result_reg <= step_res;
    end

    assign field_valid = valid_reg;
    assign field_kind  = result_reg.field_kind;
    assign entry_index = result_reg.entry_index;
    assign field_value = result_reg.field_value;
    assign record_done = result_reg.record_done;
    assign error_code  = result_reg.error_code;

endmodule

>>> rtl/core/prd_step.sv
// One-byte parse step: next parser state and the field result for that byte.
module prd_step #(
    parameter int HEADER_BYTES = 3
) (
    input  prd_pkg::parse_state_t  cur,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_record,
    output prd_pkg::parse_state_t  nxt,
    output logic                   emit,
    output prd_pkg::field_result_t res
);

    prd_pkg::parse_state_t parse_nxt;
    logic [63:0]           shifted;
    logic [4:0]            cnt_inc;
    logic                  full_word;
    logic                  full_dword;
    logic                  hdr_done;
    logic                  skip_done;

    assign shifted    = {cur.value_shift[55:0], data_byte};
    assign cnt_inc    = cur.byte_in_field + 5'd1;
    assign full_word  = (cnt_inc >= prd_pkg::LEN_WORD);
    assign full_dword = (cnt_inc >= prd_pkg::LEN_DWORD);
    assign hdr_done   = (cnt_inc >= 5'(HEADER_BYTES));
    assign skip_done  = (cnt_inc >= prd_pkg::LEN_SKIP);

    // Next state, before the record-end restart.
    always_comb
    begin
        parse_nxt = cur;
        case (cur.phase)
            prd_pkg::PH_HEADER:
            begin
                parse_nxt.byte_in_field = cnt_inc;
                if (hdr_done)
                begin
                    parse_nxt.byte_in_field = '0;
                    parse_nxt.value_shift   = '0;
                    parse_nxt.phase         = prd_pkg::PH_PID;
                end
            end
            prd_pkg::PH_PID, prd_pkg::PH_LEADER, prd_pkg::PH_LEPOCH:
            begin
                parse_nxt.value_shift   = shifted;
                parse_nxt.byte_in_field = cnt_inc;
                if (full_word)
                begin
                    parse_nxt.byte_in_field = '0;
                    parse_nxt.value_shift   = '0;
                    parse_nxt.phase         = prd_pkg::phase_t'(cur.phase + 4'd1);
                end
            end
            prd_pkg::PH_PEPOCH:
            begin
                parse_nxt.value_shift   = shifted;
                parse_nxt.byte_in_field = cnt_inc;
                if (full_word)
                begin
                    parse_nxt.byte_in_field = '0;
                    parse_nxt.value_shift   = '0;
                    parse_nxt.phase         = prd_pkg::PH_DRAIN;
                end
            end
            prd_pkg::PH_TID_HI, prd_pkg::PH_TID_LO:
            begin
                parse_nxt.value_shift   = shifted;
                parse_nxt.byte_in_field = cnt_inc;
                if (full_dword)
                begin
                    parse_nxt.byte_in_field = '0;
                    parse_nxt.value_shift   = '0;
                    parse_nxt.phase         = prd_pkg::phase_t'(cur.phase + 4'd1);
                end
            end
            prd_pkg::PH_RCOUNT, prd_pkg::PH_ICOUNT:
            begin
                if (data_byte == 8'd0)
                begin
                    parse_nxt.phase = prd_pkg::PH_DRAIN;
                end
                else
                begin
                    parse_nxt.entries_left   = data_byte - 8'd1;
                    parse_nxt.entry_position = '0;
                    parse_nxt.value_shift    = '0;
                    parse_nxt.byte_in_field  = '0;
                    if (data_byte != 8'd1)
                        parse_nxt.phase = prd_pkg::phase_t'(cur.phase + 4'd1);
                    else if (cur.phase == prd_pkg::PH_RCOUNT)
                        parse_nxt.phase = prd_pkg::PH_ICOUNT;
                    else
                        parse_nxt.phase = prd_pkg::PH_SKIP;
                end
            end
            prd_pkg::PH_REPL, prd_pkg::PH_ISR:
            begin
                parse_nxt.value_shift   = shifted;
                parse_nxt.byte_in_field = cnt_inc;
                if (full_word)
                begin
                    parse_nxt.byte_in_field  = '0;
                    parse_nxt.value_shift    = '0;
                    parse_nxt.entry_position = cur.entry_position + 8'd1;
                    parse_nxt.entries_left   = cur.entries_left - 8'd1;
                    if (cur.entries_left == 8'd1)
                        parse_nxt.phase = prd_pkg::phase_t'(cur.phase + 4'd1);
                end
            end
            prd_pkg::PH_SKIP:
            begin
                parse_nxt.byte_in_field = cnt_inc;
                if (skip_done)
                begin
                    parse_nxt.byte_in_field = '0;
                    parse_nxt.value_shift   = '0;
                    parse_nxt.phase         = prd_pkg::PH_LEADER;
                end
            end
            default:
            begin
                parse_nxt.phase = prd_pkg::PH_DRAIN;
            end
        endcase
    end

    assign nxt = end_of_record ? prd_pkg::restart_state(HEADER_BYTES > 0) : parse_nxt;

    // Result for this byte.
    always_comb
    begin
        emit = 1'b0;
        res  = '0;
        case (cur.phase)
            prd_pkg::PH_PID, prd_pkg::PH_LEADER, prd_pkg::PH_LEPOCH,
            prd_pkg::PH_PEPOCH:
            begin
                if (full_word)
                begin
                    emit            = 1'b1;
                    res.field_value = {32'd0, shifted[31:0]};
                    case (cur.phase)
                        prd_pkg::PH_PID:    res.field_kind = prd_pkg::KIND_PID;
                        prd_pkg::PH_LEADER: res.field_kind = prd_pkg::KIND_LEADER;
                        prd_pkg::PH_LEPOCH: res.field_kind = prd_pkg::KIND_LEPOCH;
                        default:
                        begin
                            res.field_kind  = prd_pkg::KIND_PEPOCH;
                            res.record_done = 1'b1;
                        end
                    endcase
                end
            end
            prd_pkg::PH_TID_HI, prd_pkg::PH_TID_LO:
            begin
                if (full_dword)
                begin
                    emit            = 1'b1;
                    res.field_value = shifted;
                    res.field_kind  = (cur.phase == prd_pkg::PH_TID_HI) ?
                                      prd_pkg::KIND_TID_HI : prd_pkg::KIND_TID_LO;
                end
            end
            prd_pkg::PH_REPL, prd_pkg::PH_ISR:
            begin
                if (full_word)
                begin
                    emit            = 1'b1;
                    res.field_value = {32'd0, shifted[31:0]};
                    res.entry_index = cur.entry_position;
                    res.field_kind  = (cur.phase == prd_pkg::PH_REPL) ?
                                      prd_pkg::KIND_REPLICA : prd_pkg::KIND_INSYNC;
                end
            end
            prd_pkg::PH_RCOUNT, prd_pkg::PH_ICOUNT:
            begin
                if (data_byte == 8'd0)
                begin
                    emit           = 1'b1;
                    res.error_code = prd_pkg::ERR_BAD_COUNT;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // Record ended before the partition epoch, no bad count: truncation overrides all.
        if (end_of_record && (parse_nxt.phase != prd_pkg::PH_DRAIN))
        begin
            emit           = 1'b1;
            res            = '0;
            res.error_code = prd_pkg::ERR_TRUNCATED;
        end
    end

endmodule

>>> rtl/core/prd_checker.sv
// Port-level assertions for the partition record decoder, bound to the top level.
module prd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  data_byte,
    input logic        end_of_record,
    input logic        field_valid,
    input logic        field_stall,
    input logic [2:0]  field_kind,
    input logic [7:0]  entry_index,
    input logic [63:0] field_value,
    input logic        record_done,
    input logic [1:0]  error_code
);

    // Held result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && field_stall |=> field_valid && $stable(field_value)
            && $stable(field_kind) && $stable(error_code))
        else $error("stalled result changed");

    // Byte side only stalls behind a stalled result.
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !field_stall |-> !byte_stall)
        else $error("byte side stalled with free result register");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && (error_code != prd_pkg::ERR_NONE) |->
            field_kind == prd_pkg::KIND_PID && entry_index == 8'd0
            && field_value == 64'd0 && !record_done)
        else $error("error result carries field data");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && record_done |->
            field_kind == prd_pkg::KIND_PEPOCH && error_code == prd_pkg::ERR_NONE)
        else $error("record_done on wrong field");

    a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && field_kind != prd_pkg::KIND_TID_HI
            && field_kind != prd_pkg::KIND_TID_LO |->
            field_value[63:32] == 32'd0
            && (entry_index == 8'd0 || field_kind == prd_pkg::KIND_REPLICA
                || field_kind == prd_pkg::KIND_INSYNC))
        else $error("32-bit field has upper bits or stray index");

endmodule

bind partition_record_decoder prd_checker u_prd_checker (.*);
